// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Defining ASSERT_OFF
// compiles every check away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: hdl/prr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_pkg
// Types, widths, register indexes and fixed constants of the PCM resampler.
// ----------------------------------------------------------------------------
package prr_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int POS_W      = 31;
    localparam int GAIN_W     = 9;
    localparam int RAW_W      = 16;
    localparam int OUT_W      = 24;
    localparam int PROD_W     = 26;
    localparam int PHASE_W    = 20;
    localparam int WP_W       = 32;
    localparam int MAX_PAIRS  = 8;
    localparam int CNT_W      = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_SAMPLE_WIDTH  = 2'd1,
        CFG_RATIO_STEP    = 2'd2
    } t_cfg_index;

    // Register codes that select mono and eight-bit operation.
    localparam logic [1:0] CHANNELS_MONO = 2'd1;
    localparam logic [1:0] WIDTH_8BIT    = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [1:0]            CHANNELS_RESET = 2'd2;
    localparam logic [1:0]            WIDTH_RESET    = 2'd2;
    localparam logic [CFG_DATA_W-1:0] STEP_RESET     = 20'h10000;

    // Offset that removes the bias of unsigned eight-bit mono data.
    localparam logic [7:0] MONO8_BIAS = 8'd128;

    typedef logic signed [OUT_W-1:0]  t_sample;
    typedef logic signed [PROD_W-1:0] t_product;

    localparam t_sample OUT_MAX = 24'sh7FFFFF;
    localparam t_sample OUT_MIN = 24'sh800000;

endpackage

// File: hdl/pcm_resample_to_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_resample_to_ring
// Nearest-neighbor PCM resampler that feeds a stereo ring buffer.
//
// Source frames arrive on the input valid/ready channel, one frame per
// transaction. Each frame is turned into a gain-scaled stereo pair and is
// repeated zero to eight times, as the 4.16 phase accumulator decides.
// Every pair leaves on the output valid/ready channel as one transaction,
// tagged with its ring slot; the last pair of a frame carries o_last.
// A frame that falls between output instants produces no transaction.
//
// Each frame passes, in order, the input register, the scaling and slot
// reduction stage and the pair sequencer; its pairs then go out through
// the output register. A frame stays in the pair sequencer until its last
// pair is emitted or it is skipped; the sequencer emits one pair a cycle
// into a single output register while the receiver does not stall, and
// the next frame can already wait in the stages in front of it.
//
// Reset (synchronous, active low) empties every stage, clears the write
// pointer and phase and loads the default configuration. When the receiver
// stalls, the output register holds its pair, the sequencer waits and the
// front stages fill before o_in_ready drops. Configuration must be written
// with i_cfg_wr_en only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcm_resample_to_ring #(
    parameter int unsigned RING_DEPTH = 16384
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // Configuration write port.
    input  logic                                i_cfg_wr_en,
    input  logic [prr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [prr_pkg::CFG_DATA_W-1:0]      i_cfg_data,

    // Source frame channel.
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_burst_start,
    input  logic [prr_pkg::POS_W-1:0]           i_play_position,
    input  logic [prr_pkg::GAIN_W-1:0]          i_gain,
    input  logic [prr_pkg::RAW_W-1:0]           i_sample_left_raw,
    input  logic [prr_pkg::RAW_W-1:0]           i_sample_right_raw,

    // Output pair channel.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [$clog2(RING_DEPTH)-1:0]       o_slot,
    output logic signed [prr_pkg::OUT_W-1:0]    o_left_out,
    output logic signed [prr_pkg::OUT_W-1:0]    o_right_out,
    output logic                                o_last
);

    localparam int SLOT_W = $clog2(RING_DEPTH);
    // Width of the remainder before its final correction (it stays below 2*depth).
    localparam int REM_W  = SLOT_W + 1;
    // Reciprocal of the depth scaled by 2^31; the quotient estimate is low by
    // at most one because the play position is below 2^31.
    localparam int M_W    = 32 - SLOT_W;
    localparam logic [M_W-1:0] RECIP = M_W'((64'd1 << 31) / RING_DEPTH);
    localparam int MUL_W  = prr_pkg::POS_W + M_W;
    localparam logic [REM_W-1:0]  DEPTH_R   = REM_W'(RING_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
    localparam logic [prr_pkg::CNT_W-1:0] CNT_LAST = prr_pkg::CNT_W'(prr_pkg::MAX_PAIRS - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]                     r_channel_count;
    logic [1:0]                     r_sample_width;
    logic [prr_pkg::CFG_DATA_W-1:0] r_ratio_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= prr_pkg::CHANNELS_RESET;
            r_sample_width  <= prr_pkg::WIDTH_RESET;
            r_ratio_step    <= prr_pkg::STEP_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                prr_pkg::CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[1:0];
                prr_pkg::CFG_SAMPLE_WIDTH:  r_sample_width  <= i_cfg_data[1:0];
                prr_pkg::CFG_RATIO_STEP:    r_ratio_step    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage loads when the stage behind it frees up.
    // ------------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_w_v, r_o_v;
    logic s1_free, s2_free, w_free, out_free;
    logic in_take, s1_move, s2_move;
    logic adv, emit, done;

    assign out_free = !r_o_v || i_out_ready;
    assign w_free   = !r_w_v || (adv && done);
    assign s2_free  = !r_s2_v || w_free;
    assign s1_free  = !r_s1_v || s2_free;
    assign in_take  = i_in_valid && s1_free;
    assign s1_move  = r_s1_v && s2_free;
    assign s2_move  = r_s2_v && w_free;

    assign o_in_ready = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_w_v  <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_v <= i_in_valid;
            end
            if (s2_free) begin
                r_s2_v <= r_s1_v;
            end
            if (w_free) begin
                r_w_v <= r_s2_v;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register.
    // ------------------------------------------------------------------
    logic                           r_s1_burst;
    logic [prr_pkg::POS_W-1:0]      r_s1_pos;
    logic [prr_pkg::GAIN_W-1:0]     r_s1_gain;
    logic [prr_pkg::RAW_W-1:0]      r_s1_left;
    logic [prr_pkg::RAW_W-1:0]      r_s1_right;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_burst <= i_burst_start;
            r_s1_pos   <= i_play_position;
            r_s1_gain  <= i_gain;
            r_s1_left  <= i_sample_left_raw;
            r_s1_right <= i_sample_right_raw;
        end
    end

    // Sample decode and gain. Eight-bit data is moved to the top byte so that
    // one multiply by gain covers the extra factor of 256.
    function automatic prr_pkg::t_sample sat24(input prr_pkg::t_product p);
        prr_pkg::t_sample res;
        if (p > prr_pkg::t_product'(prr_pkg::OUT_MAX)) begin
            res = prr_pkg::OUT_MAX;
        end else if (p < prr_pkg::t_product'(prr_pkg::OUT_MIN)) begin
            res = prr_pkg::OUT_MIN;
        end else begin
            res = p[prr_pkg::OUT_W-1:0];
        end
        return res;
    endfunction

    logic                               is_mono, is_8bit;
    logic signed [prr_pkg::RAW_W-1:0]   dec_left, dec_right;
    logic signed [prr_pkg::GAIN_W:0]    gain_s;
    prr_pkg::t_product                  prod_left, prod_right;
    logic [7:0]                         mono8;
    logic [MUL_W-1:0]                   pos_mul;

    assign is_mono = (r_channel_count == prr_pkg::CHANNELS_MONO);
    assign is_8bit = (r_sample_width == prr_pkg::WIDTH_8BIT);
    assign mono8   = r_s1_left[7:0] - prr_pkg::MONO8_BIAS;

    always_comb begin
        if (is_8bit) begin
            if (is_mono) begin
                dec_left  = {mono8, 8'h00};
                dec_right = {mono8, 8'h00};
            end else begin
                dec_left  = {r_s1_left[7:0], 8'h00};
                dec_right = {r_s1_right[7:0], 8'h00};
            end
        end else begin
            dec_left  = r_s1_left;
            dec_right = is_mono ? r_s1_left : r_s1_right;
        end
    end

    assign gain_s     = {1'b0, r_s1_gain};
    assign prod_left  = dec_left * gain_s;
    assign prod_right = dec_right * gain_s;
    assign pos_mul    = MUL_W'(r_s1_pos) * MUL_W'(RECIP);

    // ------------------------------------------------------------------
    // Stage 2: scaled samples and the quotient estimate of the position.
    // ------------------------------------------------------------------
    logic                           r_s2_burst;
    logic [prr_pkg::POS_W-1:0]      r_s2_pos;
    logic [REM_W-1:0]               r_s2_quot;
    prr_pkg::t_sample               r_s2_left, r_s2_right;

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_burst <= r_s1_burst;
            r_s2_pos   <= r_s1_pos;
            r_s2_quot  <= REM_W'(pos_mul >> 31);
            r_s2_left  <= sat24(prod_left);
            r_s2_right <= sat24(prod_right);
        end
    end

    // Remainder from the low bits only, then one correcting subtract.
    logic [REM_W-1:0]  quot_depth, rem_raw, rem_fix;

    assign quot_depth = r_s2_quot * DEPTH_R;
    assign rem_raw    = r_s2_pos[REM_W-1:0] - quot_depth;
    assign rem_fix    = (rem_raw >= DEPTH_R) ? (rem_raw - DEPTH_R) : rem_raw;

    // ------------------------------------------------------------------
    // Stage 3: pair sequencer, one pair per cycle while the output is not stalled.
    // ------------------------------------------------------------------
    logic                           r_w_burst;
    logic [prr_pkg::POS_W-1:0]      r_w_pos;
    logic [SLOT_W-1:0]              r_w_pos_slot;
    prr_pkg::t_sample               r_w_left, r_w_right;

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_w_burst    <= r_s2_burst;
            r_w_pos      <= r_s2_pos;
            r_w_pos_slot <= rem_fix[SLOT_W-1:0];
            r_w_left     <= r_s2_left;
            r_w_right    <= r_s2_right;
        end
    end

    // Write pointer, its ring slot, phase and the pair count of the frame.
    logic [prr_pkg::WP_W-1:0]       r_wp;
    logic [SLOT_W-1:0]              r_slot;
    logic [prr_pkg::PHASE_W-1:0]    r_phase;
    logic [prr_pkg::CNT_W-1:0]      r_cnt;

    logic                           first, raise;
    logic [prr_pkg::WP_W-1:0]       wp_eff;
    logic [SLOT_W-1:0]              slot_eff, slot_inc;
    logic [prr_pkg::PHASE_W-1:0]    acc_eff;
    logic [prr_pkg::PHASE_W:0]      acc_add;

    logic [prr_pkg::WP_W-1:0]       n_wp;
    logic [SLOT_W-1:0]              n_slot;
    logic [prr_pkg::PHASE_W-1:0]    n_phase;
    logic [prr_pkg::CNT_W-1:0]      n_cnt;

    assign first    = (r_cnt == '0);
    // At a burst start a lagging write pointer jumps up to the play position.
    assign raise    = first && r_w_burst && (r_wp < {1'b0, r_w_pos});
    assign wp_eff   = raise ? {1'b0, r_w_pos} : r_wp;
    assign slot_eff = raise ? r_w_pos_slot : r_slot;
    assign slot_inc = (slot_eff == SLOT_LAST) ? '0 : slot_eff + 1'b1;
    assign acc_eff  = (first && r_w_burst) ? '0 : r_phase;
    // A phase below one frame means this frame owns the next output instant.
    assign emit     = (acc_eff[prr_pkg::PHASE_W-1:16] == '0);
    assign acc_add  = {1'b0, acc_eff} + {1'b0, r_ratio_step};
    assign done     = !emit || (acc_add[prr_pkg::PHASE_W:16] != '0) || (r_cnt == CNT_LAST);
    assign adv      = r_w_v && (!emit || out_free);

    always_comb begin
        n_wp    = r_wp;
        n_slot  = r_slot;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        if (adv) begin
            if (emit) begin
                n_wp   = wp_eff + 1'b1;
                n_slot = slot_inc;
                if (done) begin
                    n_cnt = '0;
                    // When the pair cap ends the frame early the phase restarts.
                    if (acc_add[prr_pkg::PHASE_W:16] != '0) begin
                        n_phase = prr_pkg::PHASE_W'(acc_add - 21'h10000);
                    end else begin
                        n_phase = '0;
                    end
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_phase = acc_add[prr_pkg::PHASE_W-1:0];
                end
            end else begin
                // Downsampling skip: the frame yields nothing.
                n_phase = acc_eff - 20'h10000;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_slot  <= '0;
            r_phase <= '0;
            r_cnt   <= '0;
        end else begin
            r_wp    <= n_wp;
            r_slot  <= n_slot;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic [SLOT_W-1:0]  r_o_slot;
    prr_pkg::t_sample   r_o_left, r_o_right;
    logic               r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (out_free) begin
            r_o_v <= adv && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_o_slot  <= slot_eff;
            r_o_left  <= r_w_left;
            r_o_right <= r_w_right;
            r_o_last  <= done;
        end
    end

    assign o_out_valid = r_o_v;
    assign o_slot      = r_o_slot;
    assign o_left_out  = r_o_left;
    assign o_right_out = r_o_right;
    assign o_last      = r_o_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A pair count in progress needs a frame in the sequencer.
    `ASSERT_NEVER(a_cnt_needs_frame, i_clk, i_rst_n, (r_cnt != '0) && !r_w_v, "pair count without a frame")
    // The held pair is the last of its frame exactly when the count has restarted.
    `ASSERT_PROP(a_last_matches_cnt, i_clk, i_rst_n, r_o_v |-> (r_o_last == (r_cnt == '0)), "last flag and pair count disagree")
    // The next slot always follows the slot of the pair on the output.
    `ASSERT_PROP(a_slot_follows, i_clk, i_rst_n, r_o_v |-> (r_slot == ((r_o_slot == SLOT_LAST) ? '0 : r_o_slot + 1'b1)), "ring slot sequence broken")

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-neighbor PCM resampler.
//
// Source frames go in on the input valid/ready channel. A behavioral copy
// of the resampler works out the stereo pairs and ring slots that each
// accepted frame must produce, and every pair that leaves the block is
// compared field by field with the oldest pair still outstanding. A short
// directed run covers sample and gain extremes, every width code, the
// channel codes but 0, the write pointer raise at a burst start, slot
// wrap-around, frame skipping when downsampling, the eight-pair cap. Random
// bursts under changing configurations follow. Both sides stall at random.
// One phase holds the receiver off long enough to back the block up.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          RING           = 16384;
    localparam int          SLOT_W         = $clog2(RING);
    localparam int          HALF_PERIOD    = 4;
    localparam int          RESET_CYCLES   = 6;
    // Zero-pair frames can still be inside the pipeline when the last pair
    // has left; they still have to pass the stages and the sequencer.
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_PHASES  = 10;
    localparam int          PHASE_ITEMS    = 42;
    localparam int          PRESSURE_PHASE = 2;
    localparam int          CALM_PHASE     = 5;
    localparam int          IDLE_PERCENT   = 19;
    localparam logic [31:0] ONE_FRAME      = 32'h10000;
    localparam logic [30:0] POS_MAX        = '1;

    // Channel and width codes besides the ones the package names. Codes 0
    // and 3 are unused and must behave like stereo / sixteen-bit.
    localparam logic [1:0]  CODE_STEREO     = 2'd2;
    localparam logic [1:0]  CODE_16BIT      = 2'd2;
    localparam logic [1:0]  CODE_UNUSED_LOW = 2'd0;
    localparam logic [1:0]  CODE_UNUSED_TOP = 2'd3;

    // Ratio steps: the legal extremes, unity, and one below the legal range
    // that runs into the eight-pair cap with the phase still short of a frame.
    localparam logic [19:0] STEP_UP8   = 20'd8192;
    localparam logic [19:0] STEP_DOWN8 = 20'd524288;
    localparam logic [19:0] STEP_UNITY = 20'd65536;
    localparam logic [19:0] STEP_CAPPED = 20'd4096;
    localparam logic [19:0] STEP_ODD   = 20'd100000;

    typedef struct packed {
        logic        burst;
        logic [30:0] pos;
        logic [8:0]  gain;
        logic [15:0] left;
        logic [15:0] right;
    } t_frame;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        prr_pkg::t_sample  left;
        prr_pkg::t_sample  right;
        logic              last;
    } t_pair;

    // Behavioral resampler: holds the configuration, write pointer and
    // phase, and the queue of pairs the block still owes.
    class ring_writer_model;
        logic [1:0]  chans;
        logic [1:0]  width;
        logic [19:0] step;
        logic [31:0] wp;
        logic [19:0] phase;
        t_pair       pending_pairs[$];
        int          mismatches;

        function new();
            chans      = prr_pkg::CHANNELS_RESET;
            width      = prr_pkg::WIDTH_RESET;
            step       = prr_pkg::STEP_RESET;
            wp         = '0;
            phase      = '0;
            mismatches = 0;
        endfunction

        function void write_reg(prr_pkg::t_cfg_index idx,
                                logic [prr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                prr_pkg::CFG_CHANNEL_COUNT: chans = data[1:0];
                prr_pkg::CFG_SAMPLE_WIDTH:  width = data[1:0];
                prr_pkg::CFG_RATIO_STEP:    step  = data;
                default: ;
            endcase
        endfunction

        function prr_pkg::t_sample clamp(longint product);
            if (product > longint'(prr_pkg::OUT_MAX)) return prr_pkg::OUT_MAX;
            if (product < longint'(prr_pkg::OUT_MIN)) return prr_pkg::OUT_MIN;
            return prr_pkg::t_sample'(product);
        endfunction

        function void accept_frame(t_frame f);
            longint           scale;
            int               l_val;
            int               r_val;
            prr_pkg::t_sample l_out;
            prr_pkg::t_sample r_out;
            logic [31:0]      acc;
            int               n;
            t_pair            p;

            if (f.burst) begin
                if (wp < {1'b0, f.pos}) begin
                    wp = {1'b0, f.pos};
                end
                phase = '0;
            end

            scale = longint'(f.gain);
            if (width == prr_pkg::WIDTH_8BIT) begin
                scale = scale * 256;
                if (chans == prr_pkg::CHANNELS_MONO) begin
                    // Mono bytes are offset binary.
                    l_val = int'(f.left[7:0]) - int'(prr_pkg::MONO8_BIAS);
                    r_val = l_val;
                end else begin
                    l_val = $signed(f.left[7:0]);
                    r_val = $signed(f.right[7:0]);
                end
            end else begin
                l_val = $signed(f.left);
                r_val = (chans == prr_pkg::CHANNELS_MONO) ? l_val : int'($signed(f.right));
            end
            l_out = clamp(longint'(l_val) * scale);
            r_out = clamp(longint'(r_val) * scale);

            acc = {12'b0, phase};
            n   = 0;
            while (acc < ONE_FRAME && n < prr_pkg::MAX_PAIRS) begin
                p.slot  = SLOT_W'(wp % RING);
                p.left  = l_out;
                p.right = r_out;
                p.last  = 1'b0;
                pending_pairs.push_back(p);
                wp  = wp + 1;
                acc = acc + {12'b0, step};
                n++;
            end
            if (n > 0) begin
                pending_pairs[pending_pairs.size() - 1].last = 1'b1;
            end
            phase = (acc >= ONE_FRAME) ? 20'(acc - ONE_FRAME) : 20'd0;
        endfunction

        function void report(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void match_pair(t_pair got);
            t_pair want;
            if (pending_pairs.size() == 0) begin
                $display("%0t: unexpected pair, expected none, actual slot %0d left %0d right %0d",
                         $time, got.slot, got.left, got.right);
                mismatches++;
                return;
            end
            want = pending_pairs.pop_front();
            report("slot", $signed({1'b0, want.slot}), $signed({1'b0, got.slot}));
            report("left_out", want.left, got.left);
            report("right_out", want.right, got.right);
            report("last", $signed({1'b0, want.last}), $signed({1'b0, got.last}));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                           i_clk              = 1'b0;
    logic                           i_rst_n            = 1'b0;
    logic                           i_cfg_wr_en        = 1'b0;
    logic [prr_pkg::CFG_IDX_W-1:0]  i_cfg_index        = prr_pkg::CFG_CHANNEL_COUNT;
    logic [prr_pkg::CFG_DATA_W-1:0] i_cfg_data         = '0;
    logic                           i_in_valid         = 1'b0;
    logic                           o_in_ready;
    logic                           i_burst_start      = 1'b0;
    logic [prr_pkg::POS_W-1:0]      i_play_position    = '0;
    logic [prr_pkg::GAIN_W-1:0]     i_gain             = '0;
    logic [prr_pkg::RAW_W-1:0]      i_sample_left_raw  = '0;
    logic [prr_pkg::RAW_W-1:0]      i_sample_right_raw = '0;
    logic                           o_out_valid;
    logic                           i_out_ready        = 1'b0;
    logic [SLOT_W-1:0]              o_slot;
    prr_pkg::t_sample               o_left_out;
    prr_pkg::t_sample               o_right_out;
    logic                           o_last;

    ring_writer_model model = new();

    // Shared between the sender and the receiver: the stall rate of both
    // sides, and a running count of requests for the receiver to hold off
    // for a long stretch. Only the stimulus writes either of them.
    int idle_pct      = IDLE_PERCENT;
    int hold_requests = 0;
    int quiet_cycles  = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    pcm_resample_to_ring #(
        .RING_DEPTH (RING)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_burst_start      (i_burst_start),
        .i_play_position    (i_play_position),
        .i_gain             (i_gain),
        .i_sample_left_raw  (i_sample_left_raw),
        .i_sample_right_raw (i_sample_right_raw),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_slot             (o_slot),
        .o_left_out         (o_left_out),
        .o_right_out        (o_right_out),
        .o_last             (o_last)
    );

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offers one frame and returns in the time step of its transaction.
    // The handshake is judged on the values present before the edge, so
    // nothing here depends on event order inside the step.
    task automatic send_frame(input t_frame f);
        int gap;
        begin
            gap = 0;
            while ($urandom_range(0, 99) < idle_pct && gap < 6) begin
                gap++;
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid         <= 1'b1;
            i_burst_start      <= f.burst;
            i_play_position    <= f.pos;
            i_gain             <= f.gain;
            i_sample_left_raw  <= f.left;
            i_sample_right_raw <= f.right;
            do @(posedge i_clk); while (!o_in_ready);
            model.accept_frame(f);
        end
    endtask

    // Stops offering frames and waits until every owed pair has arrived,
    // then lets frames that yield nothing clear the pipeline.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (model.pending_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all three registers on consecutive edges while the block is idle.
    task automatic write_config(input logic [1:0] chans, input logic [1:0] width,
                                input logic [19:0] step);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= prr_pkg::CFG_CHANNEL_COUNT;
        i_cfg_data  <= prr_pkg::CFG_DATA_W'(chans);
        @(posedge i_clk);
        i_cfg_index <= prr_pkg::CFG_SAMPLE_WIDTH;
        i_cfg_data  <= prr_pkg::CFG_DATA_W'(width);
        @(posedge i_clk);
        i_cfg_index <= prr_pkg::CFG_RATIO_STEP;
        i_cfg_data  <= step;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        model.write_reg(prr_pkg::CFG_CHANNEL_COUNT, prr_pkg::CFG_DATA_W'(chans));
        model.write_reg(prr_pkg::CFG_SAMPLE_WIDTH, prr_pkg::CFG_DATA_W'(width));
        model.write_reg(prr_pkg::CFG_RATIO_STEP, step);
    endtask

    function automatic t_frame frame_of(input logic burst, input logic [30:0] pos,
                                        input logic [8:0] gain,
                                        input logic [15:0] left,
                                        input logic [15:0] right);
        t_frame f;
        f.burst = burst;
        f.pos   = pos;
        f.gain  = gain;
        f.left  = left;
        f.right = right;
        return f;
    endfunction

    // Raw samples lean toward the 16-bit and 8-bit extremes; the upper byte
    // stays random in the byte cases since 8-bit modes must ignore it.
    function automatic logic [15:0] random_raw();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return {8'($urandom()), 8'h7F};
            5:       return {8'($urandom()), 8'h80};
            default: return 16'($urandom());
        endcase
    endfunction

    // A burst start mostly picks a play position just ahead of the write
    // pointer (a raise) or at or behind it (no raise). The rest are drawn
    // across the whole range, which moves the pointer far up now and then.
    function automatic t_frame random_frame(input bit start);
        t_frame      f;
        logic [32:0] reach;
        int unsigned pick;

        pick    = $urandom_range(0, 99);
        f.burst = start;
        f.pos   = 31'($urandom());
        if (start && pick < 50) begin
            reach = {1'b0, model.wp} + 33'($urandom_range(1, 4000));
            f.pos = (reach > {2'b0, POS_MAX}) ? POS_MAX : reach[30:0];
        end else if (start && pick < 90 && model.wp <= {1'b0, POS_MAX}) begin
            f.pos = (model.wp[30:0] > 31'd3000) ?
                    model.wp[30:0] - 31'($urandom_range(0, 3000)) : 31'd0;
        end

        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            f.gain = 9'd256;
        end else if (pick < 30) begin
            f.gain = 9'($urandom_range(257, 511));
        end else if (pick < 35) begin
            f.gain = 9'd0;
        end else begin
            f.gain = 9'($urandom_range(0, 256));
        end
        f.left  = random_raw();
        f.right = random_raw();
        return f;
    endfunction

    // A phase of random bursts: a burst opens with a start frame and runs
    // for a few to a couple dozen frames. A stray start now and then cuts
    // a burst short.
    task automatic run_bursts(input int count);
        int remaining;
        bit start;
        begin
            remaining = 0;
            repeat (count) begin
                start = (remaining == 0) || ($urandom_range(0, 99) < 4);
                if (start) begin
                    remaining = $urandom_range(3, 24);
                end
                remaining--;
                send_frame(random_frame(start));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: checks each pair transaction, then picks the ready
    // level for the next cycle. A new hold-off request pins ready low until
    // the hold counter kept here runs out.
    // ------------------------------------------------------------------
    initial begin : receiver
        int    hold_left;
        int    holds_seen;
        t_pair got;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got.slot  = o_slot;
                got.left  = o_left_out;
                got.right = o_right_out;
                got.last  = o_last;
                model.match_pair(got);
            end
            if (hold_requests != holds_seen) begin
                hold_left  = HOLD_CYCLES;
                holds_seen = hold_requests;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // Ends the run if no transaction happens on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [19:0] step;
        logic [1:0]  chans;
        logic [1:0]  width;
        int unsigned pick;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: stereo, 16-bit, one pair per frame. Covers
        // the sample extremes, zero gain, gain above unity saturating both
        // ways, a burst start that raises the pointer and one that does not,
        // and a raise to the top slot so the next pair wraps to slot zero.
        send_frame(frame_of(1'b1, 31'd100, 9'd256, 16'h7FFF, 16'h8000));
        send_frame(frame_of(1'b0, 31'd0, 9'd256, 16'h0000, 16'hFFFF));
        send_frame(frame_of(1'b0, 31'd0, 9'd0, 16'h7FFF, 16'h8000));
        send_frame(frame_of(1'b0, 31'd0, 9'd511, 16'h7FFF, 16'h8000));
        send_frame(frame_of(1'b1, 31'd50, 9'd300, 16'h1234, 16'hEDCB));
        send_frame(frame_of(1'b1, 31'd16383, 9'd256, 16'h8000, 16'h7FFF));
        send_frame(frame_of(1'b0, 31'd0, 9'd1, 16'hFFFF, 16'h0001));

        // Mono 8-bit upsampled by eight: offset-binary bytes at the bottom,
        // the midpoint and the top, with junk in the unused upper byte.
        write_config(prr_pkg::CHANNELS_MONO, prr_pkg::WIDTH_8BIT, STEP_UP8);
        send_frame(frame_of(1'b1, 31'd30000, 9'd256, 16'h5A00, 16'h1234));
        send_frame(frame_of(1'b0, 31'd0, 9'd511, 16'hAB80, 16'hFFFF));
        send_frame(frame_of(1'b0, 31'd0, 9'd511, 16'h00FF, 16'h0000));
        send_frame(frame_of(1'b0, 31'd0, 9'd256, 16'hFF00, 16'h8000));

        // Stereo 8-bit downsampled by eight: after the first pair the next
        // frames fall between output instants and yield nothing, until a
        // new burst resets the phase.
        write_config(CODE_STEREO, prr_pkg::WIDTH_8BIT, STEP_DOWN8);
        send_frame(frame_of(1'b1, 31'd40000, 9'd256, 16'h0080, 16'h007F));
        send_frame(frame_of(1'b0, 31'd0, 9'd256, 16'hFF7F, 16'h0080));
        send_frame(frame_of(1'b0, 31'd0, 9'd300, 16'h0001, 16'h00FF));
        send_frame(frame_of(1'b0, 31'd0, 9'd256, 16'h0000, 16'h0000));
        send_frame(frame_of(1'b1, 31'd0, 9'd511, 16'h0080, 16'h007F));

        // Unused register codes act as stereo 16-bit. A step below the legal
        // range hits the eight-pair cap with the phase short of a full frame.
        write_config(CODE_UNUSED_TOP, CODE_UNUSED_LOW, STEP_CAPPED);
        send_frame(frame_of(1'b1, 31'd0, 9'd256, 16'h8000, 16'h7FFF));
        send_frame(frame_of(1'b0, 31'd0, 9'd511, 16'h7FFF, 16'h8000));

        // Mono 16-bit with an uneven step: the right input is ignored.
        write_config(prr_pkg::CHANNELS_MONO, CODE_UNUSED_TOP, STEP_ODD);
        send_frame(frame_of(1'b1, 31'd60000, 9'd256, 16'h8001, 16'h7FFF));
        send_frame(frame_of(1'b0, 31'd0, 9'd400, 16'h7FFF, 16'h0000));
        send_frame(frame_of(1'b0, 31'd0, 9'd128, 16'hC000, 16'h1111));
        send_frame(frame_of(1'b0, 31'd0, 9'd256, 16'h0001, 16'hFFFF));

        // Random bursts, a fresh configuration per phase. Steps favor the
        // extremes and unity; some fall below the legal range.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            pick  = $urandom_range(0, 9);
            chans = 2'($urandom_range(0, 3));
            width = 2'($urandom_range(0, 3));
            case (pick)
                0:       step = STEP_UP8;
                1:       step = STEP_DOWN8;
                2:       step = STEP_UNITY;
                3:       step = 20'($urandom_range(1, 8191));
                default: step = 20'($urandom_range(8192, 524288));
            endcase
            // Eight pairs per frame back the block up fastest.
            if (p == PRESSURE_PHASE) begin
                step = STEP_UP8;
            end
            write_config(chans, width, step);
            idle_pct = (p == CALM_PHASE) ? 0 : IDLE_PERCENT;
            if (p == PRESSURE_PHASE) begin
                hold_requests++;
            end
            run_bursts(PHASE_ITEMS);
        end

        // Play position at its maximum. Placed last because the write
        // pointer can never be raised again once it gets there.
        write_config(CODE_STEREO, CODE_16BIT, STEP_UNITY);
        idle_pct = IDLE_PERCENT;
        send_frame(frame_of(1'b1, POS_MAX, 9'd256, 16'h4000, 16'hC000));
        send_frame(frame_of(1'b0, 31'd0, 9'd256, 16'h0100, 16'hFF00));

        wait_drained();
        if (model.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/prr_pkg.sv
hdl/pcm_resample_to_ring.sv
bench/testbench.sv
